FILE: sv/bdc_pkg.sv
package bdc_pkg;
  localparam int unsigned MaxTermsDefault = 1024;
  localparam logic [2:0] StatOk = 3'd0;
  localparam logic [2:0] StatNoTerms = 3'd1;
  localparam logic [2:0] StatBadFreq = 3'd2;
  localparam logic [2:0] StatZeroPrice = 3'd3;
  localparam logic [2:0] StatTooMany = 3'd4;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  // months per term for a valid frequency, zero otherwise
  function automatic logic [3:0] term_months(input logic [3:0] f);
    logic [3:0] m;
    m = 4'd0;
    unique case (f)
      4'd1: m = 4'd12;
      4'd2: m = 4'd6;
      4'd3: m = 4'd4;
      4'd4: m = 4'd3;
      4'd6: m = 4'd2;
      4'd12: m = 4'd1;
      default: m = 4'd0;
    endcase
    return m;
  endfunction
endpackage

FILE: sv/bdc_div.sv
module bdc_div
  import bdc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  div_req_t    req_i,
  output logic        done_o,
  output logic [63:0] quot_o,
  output logic [63:0] rem_o
);
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [63:0] q_q, q_d, r_q, r_d, den_q, den_d;
  logic [64:0] trial;

  // restoring division, one quotient bit a cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d = cnt_q;
    q_d = q_q;
    r_d = r_q;
    den_d = den_q;
    trial = {r_q, q_q[63]} - {1'b0, den_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d = 7'd0;
      q_d = req_i.num;
      r_d = '0;
      den_d = req_i.den;
    end else if (busy_q) begin
      if (!trial[64]) begin
        r_d = trial[63:0];
        q_d = {q_q[62:0], 1'b1};
      end else begin
        r_d = {r_q[62:0], q_q[63]};
        q_d = {q_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = q_q;
  assign rem_o = r_q;
endmodule

FILE: sv/bond_duration_calculator_top.sv
// a result takes five passes through the shared bit-serial divider and, per coupon term,
// a coupon product and an accumulate on the shared multiplier (plus a discount product
// for each term after the first); the remainder pass is skipped when macaulay saturates
// transactions: one at a time, the next accepted in the cycle after the result is taken
// error cases: a bad frequency goes out without a division, the other status codes after the term count division
// reset: asynchronous active low, clears the sequencer and output valid
module bond_duration_calculator_top
  import bdc_pkg::*;
#(
  parameter int unsigned MaxTerms = MaxTermsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [11:0] maturity_year_i,
  input  logic [3:0]  maturity_month_i,
  input  logic [11:0] settlement_year_i,
  input  logic [3:0]  settlement_month_i,
  input  logic [3:0]  payments_per_year_i,
  input  logic [23:0] bond_price_i,
  input  logic [23:0] coupon_per_period_i,
  input  logic [23:0] yield_per_period_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] macaulay_years_o,
  output logic [31:0] modified_years_o,
  output logic [2:0]  status_o
);
  localparam int NW = $clog2(MaxTerms + 1) + 1;

  localparam logic [3:0] SIdle = 4'd0;
  localparam logic [3:0] SSpan = 4'd1;
  localparam logic [3:0] SNdiv = 4'd2;
  localparam logic [3:0] SCheck = 4'd3;
  localparam logic [3:0] SDisc = 4'd4;
  localparam logic [3:0] SMulD = 4'd5;
  localparam logic [3:0] SMulC = 4'd6;
  localparam logic [3:0] SFace = 4'd7;
  localparam logic [3:0] SDivQ = 4'd8;
  localparam logic [3:0] SDivR = 4'd9;
  localparam logic [3:0] SDivM = 4'd10;
  localparam logic [3:0] SOut = 4'd11;
  localparam logic [3:0] SAccC = 4'd12;
  localparam logic [3:0] SAccF = 4'd13;

  logic [3:0]  st_q, st_d;
  logic [11:0] my_q, sy_q;
  logic [3:0]  mm_q, sm_q, fr_q;
  logic [23:0] pr_q, cp_q, yl_q;
  logic [16:0] span_q;       // signed
  logic [31:0] d_q, disc_q;
  logic [NW-1:0] n_q, i_q;
  logic [63:0] sum_q, q_q, prod_q;
  logic [31:0] mac_q, mod_q;
  logic [2:0]  stat_q;
  logic        ov_q;
  logic        wait_q;

  div_req_t    dreq;
  logic        ddone;
  logic [63:0] dquot, drem;
  logic [3:0]  tm;
  logic [16:0] span_abs;
  logic [27:0] pf;

  bdc_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (dreq),
    .done_o(ddone),
    .quot_o(dquot),
    .rem_o (drem)
  );

  assign tm = term_months(fr_q);
  assign span_abs = span_q[16] ? 17'd0 - span_q : span_q;
  assign in_stall_o = (st_q != SIdle);
  // price times frequency, the macaulay divisor
  assign pf = {4'd0, pr_q} * {24'd0, fr_q};

  // shared multiplier, one product per cycle, combinational; its products are registered by the sequencer
  // a term takes a discount product (not the first term), a coupon product, then its weighting by the term index
  logic [31:0] ma, mb;
  logic [63:0] mprod;
  always_comb begin
    ma = disc_q;
    mb = d_q;
    if (st_q == SMulC) mb = {8'd0, cp_q};
    else if (st_q == SFace) mb = 32'd100;
    else if (st_q == SAccC) begin
      ma = prod_q[55:24];
      mb = {{(32-NW){1'b0}}, i_q};
    end else if (st_q == SAccF) begin
      ma = prod_q[39:8];
      mb = {{(32-NW){1'b0}}, n_q};
    end
  end
  assign mprod = 64'(ma) * 64'(mb);

  always_comb begin
    st_d = st_q;
    dreq = '0;
    unique case (st_q)
      SIdle: if (in_valid_i) st_d = SSpan;
      SSpan: st_d = SNdiv;
      SNdiv: begin
        if (tm == 4'd0) st_d = SOut;
        else begin
          dreq.start = !wait_q;
          dreq.num = {47'd0, span_abs};
          dreq.den = {60'd0, tm};
          if (ddone) st_d = SCheck;
        end
      end
      SCheck: st_d = (stat_q != StatOk) ? SOut : SDisc;
      SDisc: begin
        dreq.start = !wait_q;
        dreq.num = 64'd1 << 56;
        dreq.den = {39'd0, 1'b1, yl_q};
        if (ddone) st_d = SMulC;
      end
      SMulD: st_d = SMulC;
      SMulC: st_d = SAccC;
      SAccC: st_d = (i_q == n_q) ? SFace : SMulD;
      SFace: st_d = SAccF;
      SAccF: st_d = SDivQ;
      SDivQ: begin
        dreq.start = !wait_q;
        dreq.num = sum_q;
        dreq.den = {36'd0, pf};
        if (ddone) st_d = SDivR;
      end
      SDivR: begin
        dreq.start = !wait_q;
        dreq.num = {drem[55:0], 8'd0};
        dreq.den = {36'd0, pf};
        if (ov_q) st_d = SDivM;
        else if (ddone) st_d = SDivM;
      end
      SDivM: begin
        dreq.start = !wait_q;
        dreq.num = {8'd0, mac_q, 24'd0};
        dreq.den = {39'd0, 1'b1, yl_q};
        if (ddone) st_d = SOut;
      end
      SOut: if (!out_stall_i) st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      wait_q <= 1'b0;
    end else begin
      st_q <= st_d;
      // divider is kicked once on entry to a dividing state
      wait_q <= (st_d == st_q) && (dreq.start || wait_q);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      SIdle: begin
        my_q <= maturity_year_i;
        mm_q <= maturity_month_i;
        sy_q <= settlement_year_i;
        sm_q <= settlement_month_i;
        fr_q <= payments_per_year_i;
        pr_q <= bond_price_i;
        cp_q <= coupon_per_period_i;
        yl_q <= yield_per_period_i;
        stat_q <= StatOk;
        mac_q <= '0;
        mod_q <= '0;
      end
      SSpan: span_q <= ({5'd0, my_q} - {5'd0, sy_q}) * 17'sd12
                     + {13'd0, mm_q} - {13'd0, sm_q} + 17'd1;
      SNdiv: begin
        if (tm == 4'd0) stat_q <= StatBadFreq;
        else if (ddone) begin
          if (span_q[16] || dquot == 64'd0) stat_q <= StatNoTerms;
          else if (dquot > 64'(MaxTerms)) stat_q <= StatTooMany;
          else if (pr_q == 24'd0) stat_q <= StatZeroPrice;
          n_q <= dquot[NW-1:0];
        end
      end
      SCheck: begin
        sum_q <= '0;
        i_q <= {{(NW-1){1'b0}}, 1'b1};
      end
      SDisc: if (ddone) begin
        d_q <= (dquot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : dquot[31:0];
        disc_q <= (dquot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : dquot[31:0];
      end
      SMulD: begin
        disc_q <= mprod[63:32];
        i_q <= i_q + NW'(1);
      end
      SMulC: prod_q <= mprod;
      SAccC: sum_q <= sum_q + mprod;
      SFace: prod_q <= mprod;
      SAccF: sum_q <= sum_q + mprod;
      SDivQ: if (ddone) begin
        q_q <= dquot;
        ov_q <= dquot > 64'h00FF_FFFF;
      end
      SDivR: begin
        if (ov_q) mac_q <= 32'hFFFF_FFFF;
        else if (ddone) mac_q <= {q_q[23:0], 8'd0} + dquot[31:0];
      end
      SDivM: if (ddone) mod_q <= dquot[31:0];
      default: ;
    endcase
  end

  assign out_valid_o = (st_q == SOut);
  assign macaulay_years_o = (stat_q == StatOk) ? mac_q : 32'd0;
  assign modified_years_o = (stat_q == StatOk) ? mod_q : 32'd0;
  assign status_o = stat_q;
endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top
  import bdc_pkg::*;
();

  localparam int unsigned NumTerms = MaxTermsDefault;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned DrainCycles = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [11:0] maturity_year_i = '0;
  logic [3:0]  maturity_month_i = '0;
  logic [11:0] settlement_year_i = '0;
  logic [3:0]  settlement_month_i = '0;
  logic [3:0]  payments_per_year_i = '0;
  logic [23:0] bond_price_i = '0;
  logic [23:0] coupon_per_period_i = '0;
  logic [23:0] yield_per_period_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] macaulay_years_o;
  logic [31:0] modified_years_o;
  logic [2:0]  status_o;

  typedef struct packed {
    logic [11:0] mat_year;
    logic [3:0]  mat_month;
    logic [11:0] set_year;
    logic [3:0]  set_month;
    logic [3:0]  freq;
    logic [23:0] price;
    logic [23:0] coupon;
    logic [23:0] yld;
  } bond_t;

  typedef struct packed {
    logic [31:0] macaulay;
    logic [31:0] modified;
    logic [2:0]  status;
  } duration_t;

  // expected durations in acceptance order
  duration_t   exp_mem[8];
  int unsigned exp_wr = 0;
  int unsigned exp_rd = 0;
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  bit          quiet_phase = 1'b0;
  bit          sink_stall_on = 1'b1;

  bond_duration_calculator_top dut (.*);

  always #4 clk_i = ~clk_i;

  // predicted durations for one bond
  function automatic duration_t bond_duration(input bond_t b);
    duration_t   res;
    longint      span;
    longint      terms;
    logic [63:0] disc_step;
    logic [63:0] disc;
    logic [63:0] acc;
    logic [63:0] den;
    logic [63:0] quo;
    logic [63:0] rem;
    logic [63:0] mac;
    res = '0;
    if (term_months_ok(b.freq) == 0) begin
      res.status = StatBadFreq;
      return res;
    end
    span = (longint'(b.mat_year) - longint'(b.set_year)) * 12
         + (longint'(b.mat_month) - longint'(b.set_month) + 1);
    terms = span / longint'(term_months_ok(b.freq));
    if (terms < 1) begin
      res.status = StatNoTerms;
    end else if (terms > NumTerms) begin
      res.status = StatTooMany;
    end else if (b.price == 0) begin
      res.status = StatZeroPrice;
    end else begin
      disc_step = (64'd1 << 56) / (64'd16777216 + 64'(b.yld));
      if (disc_step > 64'hFFFF_FFFF) disc_step = 64'hFFFF_FFFF;
      disc = disc_step;
      acc = '0;
      for (longint i = 1; i <= terms; i++) begin
        if (i > 1) disc = (disc * disc_step) >> 32;
        acc += 64'(i) * ((64'(b.coupon) * disc) >> 24);
        if (i == terms) acc += 64'(terms) * ((64'd100 * disc) >> 8);
      end
      den = 64'(b.price) * 64'(b.freq);
      quo = acc / den;
      rem = acc % den;
      if (quo > 64'h00FF_FFFF) begin
        mac = 64'hFFFF_FFFF;
      end else begin
        mac = (quo << 8) + ((rem << 8) / den);
        if (mac > 64'hFFFF_FFFF) mac = 64'hFFFF_FFFF;
      end
      res.macaulay = mac[31:0];
      res.modified = 32'(((mac << 24) / (64'd16777216 + 64'(b.yld))));
      res.status = StatOk;
    end
    return res;
  endfunction

  // own table of months per term, zero for an unusable frequency
  function automatic int term_months_ok(input logic [3:0] f);
    case (f)
      4'd1: return 12;
      4'd2: return 6;
      4'd3: return 4;
      4'd4: return 3;
      4'd6: return 2;
      4'd12: return 1;
      default: return 0;
    endcase
  endfunction

  // random idle burst with in_valid low, now and then
  task automatic maybe_idle();
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // send one bond and record its expected durations at acceptance
  task automatic send_bond(input bond_t b);
    maybe_idle();
    in_valid_i <= 1'b1;
    maturity_year_i <= b.mat_year;
    maturity_month_i <= b.mat_month;
    settlement_year_i <= b.set_year;
    settlement_month_i <= b.set_month;
    payments_per_year_i <= b.freq;
    bond_price_i <= b.price;
    coupon_per_period_i <= b.coupon;
    yield_per_period_i <= b.yld;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    exp_mem[exp_wr[2:0]] = bond_duration(b);
    exp_wr++;
  endtask

  // bond with a chosen term count, random content
  function automatic bond_t bond_with_terms(input int n, input logic [3:0] f);
    bond_t b;
    int    months;
    months = n * (12 / int'(f));
    b.set_year = 12'($urandom_range(0, 3000));
    b.set_month = 4'($urandom_range(1, 12));
    // maturity month chosen so the inclusive span is exactly months
    b.mat_year = b.set_year + 12'((int'(b.set_month) - 1 + months - 1) / 12);
    b.mat_month = 4'((int'(b.set_month) - 1 + months - 1) % 12 + 1);
    b.freq = f;
    b.price = 24'($urandom_range(1, 24'hFF_FFFF));
    b.coupon = 24'($urandom);
    b.yld = 24'($urandom);
    return b;
  endfunction

  function automatic logic [3:0] good_freq();
    logic [3:0] opts[6] = '{4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd12};
    return opts[$urandom_range(0, 5)];
  endfunction

  // check each result transaction against the oldest expectation
  always @(posedge clk_i) begin
    duration_t exp_d;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (exp_rd == exp_wr) begin
        $display("%0t unexpected result mac %h mod %h status %0d", $time,
                 macaulay_years_o, modified_years_o, status_o);
        error_count++;
      end else begin
        exp_d = exp_mem[exp_rd[2:0]];
        exp_rd++;
        if (macaulay_years_o !== exp_d.macaulay) begin
          $display("%0t macaulay expected %h actual %h", $time, exp_d.macaulay,
                   macaulay_years_o);
          error_count++;
        end
        if (modified_years_o !== exp_d.modified) begin
          $display("%0t modified expected %h actual %h", $time, exp_d.modified,
                   modified_years_o);
          error_count++;
        end
        if (status_o !== exp_d.status) begin
          $display("%0t status expected %0d actual %0d", $time, exp_d.status,
                   status_o);
          error_count++;
        end
      end
    end
  end

  // receiver stall in random bursts
  always @(posedge clk_i) begin
    if (quiet_phase || !sink_stall_on) begin
      out_stall_i <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("FAIL bond_duration_calculator_top");
        $finish;
      end
    end
  end

  task automatic test_special_cases();
    bond_t      b;
    logic [3:0] bad_freqs[4];
    bad_freqs = '{4'd0, 4'd5, 4'd7, 4'd15};
    // unusable frequencies, zero and top codes included
    foreach (bad_freqs[k]) begin
      b = bond_with_terms(3, 4'd1);
      b.freq = bad_freqs[k];
      send_bond(b);
    end
    // no terms: negative span and a span shorter than a term
    b = bond_with_terms(1, 4'd2);
    b.mat_year = 12'd0;
    b.set_year = 12'hFFF;
    send_bond(b);
    b = bond_with_terms(1, 4'd1);
    b.mat_month = b.set_month;
    b.mat_year = b.set_year;
    send_bond(b);
    // too many terms, with the full year range
    b = bond_with_terms(2, 4'd12);
    b.mat_year = 12'hFFF;
    b.set_year = 12'd0;
    send_bond(b);
    send_bond(bond_with_terms(NumTerms + 1, 4'd12));
    // zero price
    b = bond_with_terms(5, 4'd4);
    b.price = '0;
    send_bond(b);
    // month codes outside 1..12 used as plain numbers
    b = bond_with_terms(2, 4'd1);
    b.mat_month = 4'd15;
    b.set_month = 4'd0;
    send_bond(b);
  endtask

  task automatic test_extremes();
    bond_t      b;
    logic [3:0] freqs[6];
    freqs = '{4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd12};
    // one term and the largest count
    send_bond(bond_with_terms(1, 4'd1));
    send_bond(bond_with_terms(NumTerms, 4'd12));
    // zero yield keeps the discount at its top value
    b = bond_with_terms(10, 4'd2);
    b.yld = '0;
    send_bond(b);
    // tiny price drives macaulay into saturation
    b = bond_with_terms(50, 4'd1);
    b.price = 24'd1;
    b.coupon = 24'hFF_FFFF;
    b.yld = '0;
    send_bond(b);
    // largest yield, largest price, zero and full coupon
    b = bond_with_terms(8, 4'd3);
    b.yld = 24'hFF_FFFF;
    b.price = 24'hFF_FFFF;
    b.coupon = '0;
    send_bond(b);
    b.coupon = 24'hFF_FFFF;
    send_bond(b);
    foreach (freqs[k]) begin
      send_bond(bond_with_terms($urandom_range(1, 20), freqs[k]));
    end
  endtask

  task automatic test_random_bonds(input int count);
    bond_t b;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        0: begin
          // raw noise over every field
          b = bond_t'(108'({$urandom, $urandom, $urandom, $urandom}));
        end
        1: begin
          b = bond_with_terms($urandom_range(1, 60), good_freq());
          b.price = ($urandom_range(0, 7) == 0) ? '0 : b.price;
          b.freq = ($urandom_range(0, 1) == 0) ? 4'($urandom) : b.freq;
        end
        2: b = bond_with_terms($urandom_range(1, NumTerms), good_freq());
        default: b = bond_with_terms($urandom_range(1, 40), good_freq());
      endcase
      send_bond(b);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_cases();
    test_extremes();
    test_random_bonds(340);
    quiet_phase = 1'b1;
    test_random_bonds(40);
    in_valid_i <= 1'b0;
    while (exp_rd != exp_wr) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS bond_duration_calculator_top");
    end else begin
      $display("FAIL bond_duration_calculator_top");
    end
    $finish;
  end
endmodule
